/* rtl/dfq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfq_pkg
// Shared constants, status codes and command type of the dedup FIFO queue.
// ----------------------------------------------------------------------------
package dfq_pkg;

    localparam int DEPTH     = 16;
    localparam int ITEM_BITS = 16;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed field widths on the ports
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 3;
    localparam int FILL_W   = 5;
    localparam int OUT_W    = 24;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_DUP_IGNORED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_DUP_REPLACED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL    = 3'd4;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic POLICY_IGNORE = 1'b0;
    localparam logic POLICY_DELETE = 1'b1;

    // Register index of dup_policy
    localparam logic REG_DUP_POLICY = 1'b0;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the accepted item
        logic search;  // compare against stored entries, hold match
        logic apply;   // update store and count, load result register
    } t_dp_cmd;

endpackage

/* rtl/dfq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfq_ctrl
// Sequencer: capture, search, apply; owns the result valid flag.
// ----------------------------------------------------------------------------
module dfq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output dfq_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SRCH  = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_slot_free;

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        n_out_valid  = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SRCH;
                end
            end
            S_SRCH: begin
                o_cmd.search = 1'b1;
                n_state      = S_APPLY;
            end
            S_APPLY: begin
                // hold until the result register can take the new item
                if (w_slot_free) begin
                    o_cmd.apply = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/dfq_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfq_dpath
// Entry registers, parallel equality search, close-up/append and result.
// ----------------------------------------------------------------------------
module dfq_dpath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dfq_pkg::t_dp_cmd               i_cmd,
    input  logic                           i_op,
    input  logic [dfq_pkg::VALUE_W-1:0]    i_value,
    input  logic                           i_dup_policy,
    output logic [dfq_pkg::VALUE_W-1:0]    o_pop_value,
    output logic [dfq_pkg::STATUS_W-1:0]   o_status,
    output logic                           o_is_empty,
    output logic [dfq_pkg::FILL_W-1:0]     o_fill_count
);

    logic [dfq_pkg::ITEM_BITS-1:0] r_store [dfq_pkg::DEPTH];
    logic [dfq_pkg::ITEM_BITS-1:0] n_store [dfq_pkg::DEPTH];
    logic [dfq_pkg::CNT_W-1:0]     r_cnt;
    logic [dfq_pkg::CNT_W-1:0]     n_cnt;

    logic                          r_op;
    logic [dfq_pkg::ITEM_BITS-1:0] r_value;
    logic                          r_found;
    logic [dfq_pkg::IDX_W-1:0]     r_pos;
    logic                          w_found;
    logic [dfq_pkg::IDX_W-1:0]     w_pos;

    logic                          w_rm;
    logic [dfq_pkg::IDX_W-1:0]     w_rm_pos;
    logic                          w_app;
    logic [dfq_pkg::CNT_W-1:0]     w_cnt1;
    logic [dfq_pkg::STATUS_W-1:0]  w_status;
    logic [dfq_pkg::ITEM_BITS-1:0] w_popped;

    logic [dfq_pkg::VALUE_W-1:0]   r_pop_value;
    logic [dfq_pkg::STATUS_W-1:0]  r_status;
    logic [dfq_pkg::CNT_W-1:0]     r_fill;

    // Lowest matching valid entry wins
    always_comb begin
        w_found = 1'b0;
        w_pos   = '0;
        for (int i = dfq_pkg::DEPTH - 1; i >= 0; i--) begin
            if ((dfq_pkg::CNT_W'(i) < r_cnt) && (r_store[i] == r_value)) begin
                w_found = 1'b1;
                w_pos   = dfq_pkg::IDX_W'(i);
            end
        end
    end

    // Remove (pop front or old duplicate), then append at the back
    always_comb begin
        w_status = dfq_pkg::ST_OK;
        w_rm     = 1'b0;
        w_rm_pos = '0;
        w_app    = 1'b0;
        w_popped = '0;
        if (r_op == dfq_pkg::OP_POP) begin
            if (r_cnt == '0) begin
                w_status = dfq_pkg::ST_POP_EMPTY;
            end else begin
                w_rm     = 1'b1;
                w_popped = r_store[0];
            end
        end else if (r_found && (i_dup_policy == dfq_pkg::POLICY_IGNORE)) begin
            w_status = dfq_pkg::ST_DUP_IGNORED;
        end else begin
            if (r_found) begin
                w_rm     = 1'b1;
                w_rm_pos = r_pos;
                w_status = dfq_pkg::ST_DUP_REPLACED;
            end
        end
        w_cnt1 = r_cnt - dfq_pkg::CNT_W'(w_rm);
        if ((r_op == dfq_pkg::OP_PUSH) && (w_status != dfq_pkg::ST_DUP_IGNORED)) begin
            if (w_cnt1 < dfq_pkg::CNT_W'(dfq_pkg::DEPTH)) begin
                w_app = 1'b1;
            end else begin
                w_status = dfq_pkg::ST_PUSH_FULL;
            end
        end
        n_cnt = w_cnt1 + dfq_pkg::CNT_W'(w_app);
    end

    always_comb begin
        for (int i = 0; i < dfq_pkg::DEPTH; i++) begin
            n_store[i] = r_store[i];
            if (w_rm && (dfq_pkg::IDX_W'(i) >= w_rm_pos) && (i < dfq_pkg::DEPTH - 1)) begin
                n_store[i] = r_store[(i + 1) % dfq_pkg::DEPTH];
            end
            if (w_app && (dfq_pkg::CNT_W'(i) == w_cnt1)) begin
                n_store[i] = r_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_value <= i_value[dfq_pkg::ITEM_BITS-1:0];
        end
        if (i_cmd.search) begin
            r_found <= w_found;
            r_pos   <= w_pos;
        end
        if (i_cmd.apply) begin
            r_store     <= n_store;
            r_pop_value <= dfq_pkg::VALUE_W'(w_popped);
            r_status    <= w_status;
            r_fill      <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.apply) begin
            r_cnt <= n_cnt;
        end
    end

    assign o_pop_value  = r_pop_value;
    assign o_status     = r_status;
    assign o_is_empty   = (r_fill == '0);
    assign o_fill_count = dfq_pkg::FILL_W'(r_fill);

endmodule

/* rtl/dedup_fifo_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_fifo_queue
// FIFO of item values that never holds two equal entries, with push/pop
// items in and one result item out per input item.
// ----------------------------------------------------------------------------
//
//  channel    | direction | tdata                              | tuser
//  -----------+-----------+------------------------------------+-------------
//  s_axis     | in        | [15:0] item_value                  | [0] operation
//  m_axis     | out       | [15:0] pop_value, [16] is_empty,   | [2:0] status
//             |           | [21:17] fill_count, [23:22] zero   |
//  APB        | config    | 0x0 dup_policy (bit 0)             | -
//
//  An item passes through capture, search (parallel equality compare of all
//  entries against the value), apply (close-up shift plus append). One item
//  is in work at a time; the input is ready again once the apply finishes.
//  The result register decouples the output: a new item is accepted while a
//  result waits, and only the apply step stalls on a full result register.
//  Reset (synchronous, active low) empties the queue and sets ignore-new mode;
//  no clearing pass is needed, since entries at or beyond the count are
//  never read.
//
module dedup_fifo_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,    // [15:0] item_value
    input  logic        s_axis_tuser,    // [0] operation

    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // [15:0] pop_value, [16] is_empty,
                                         // [21:17] fill_count, [23:22] zero
    output logic [2:0]  m_axis_tuser,    // [2:0] status

    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    dfq_pkg::t_dp_cmd                w_cmd;
    logic                            r_dup_policy;
    logic [dfq_pkg::VALUE_W-1:0]     w_pop_value;
    logic [dfq_pkg::STATUS_W-1:0]    w_status;
    logic                            w_is_empty;
    logic [dfq_pkg::FILL_W-1:0]      w_fill_count;
    logic                            w_reg_sel;

    // Register index comes from the word address; byte offset is ignored
    assign w_reg_sel = (paddr[2] == dfq_pkg::REG_DUP_POLICY);
    assign pready    = 1'b1;
    assign prdata    = w_reg_sel ? {31'd0, r_dup_policy} : 32'd0;

    // Keep only the low bit of the written word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dup_policy <= dfq_pkg::POLICY_IGNORE;
        end else if (psel && penable && pwrite && pready && w_reg_sel) begin
            r_dup_policy <= pwdata[0];
        end
    end

    dfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (w_cmd)
    );

    dfq_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_op         (s_axis_tuser),
        .i_value      (s_axis_tdata),
        .i_dup_policy (r_dup_policy),
        .o_pop_value  (w_pop_value),
        .o_status     (w_status),
        .o_is_empty   (w_is_empty),
        .o_fill_count (w_fill_count)
    );

    // Pack the result fields, lowest field first, pad to whole bytes
    assign m_axis_tdata = {2'b00, w_fill_count, w_is_empty, w_pop_value};
    assign m_axis_tuser = w_status;

endmodule

/* rtl/dfq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfq_checker
// Port-level checks of the dedup FIFO queue, bound to the top level.
// ----------------------------------------------------------------------------
module dfq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // Only one item in work: ready drops right after an accept
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // Empty flag agrees with the fill count
    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[16] == (m_axis_tdata[21:17] == 5'd0)))
        else $error("is_empty disagrees with fill_count");

    // Fill count never exceeds the depth
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[21:17] <= 5'(dfq_pkg::DEPTH)))
        else $error("fill_count beyond depth");

    // A failed pop returns zero on an empty queue
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == dfq_pkg::ST_POP_EMPTY))
        |-> ((m_axis_tdata[15:0] == 16'd0) && (m_axis_tdata[21:17] == 5'd0)))
        else $error("pop on empty with data or entries");

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind dedup_fifo_queue dfq_checker u_dfq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
